// ===== sv/fpv_pkg.sv =====
`timescale 1ns / 1ps
// Package for the firmware package validator: constants, status codes,
// register indexes, the header accumulator type and the CRC and BCD helpers.
// Depends on nothing; every other file of the block imports it.
package fpv_pkg;

	localparam int unsigned MAX_FILE_BYTES_DEF = 262144;
	localparam int unsigned HEADER_BYTES_DEF   = 18;

	// Fixed widths of the payload fields.
	localparam int unsigned DLEN_W = 25;
	localparam int unsigned CFG_DATA_W = 32;

	// Byte offsets inside the package header.
	localparam int unsigned POS_VER       = 8;
	localparam int unsigned POS_CRC_FIELD = 12;
	localparam int unsigned POS_CRC_START = 14;
	localparam int unsigned POS_LEN_END   = 18;

	localparam logic [7:0] MAGIC [8] = '{8'h41, 8'h70, 8'h70, 8'h42,
		8'h69, 8'h6E, 8'h20, 8'h20};

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Result status codes.
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_HEADER = 3'd1;
	localparam logic [2:0] ST_MAJOR  = 3'd2;
	localparam logic [2:0] ST_MINOR  = 3'd3;
	localparam logic [2:0] ST_CRC    = 3'd4;
	localparam logic [2:0] ST_LENGTH = 3'd5;
	localparam logic [2:0] ST_TRUNC  = 3'd6;

	// Configuration register indexes.
	localparam logic CFG_CUR_VER = 1'b0;
	localparam logic CFG_VER_EN  = 1'b1;

	typedef struct packed {
		logic        hdr_bad;
		logic [31:0] pkg_ver;
		logic [15:0] stored_crc;
		logic [15:0] run_crc;
		logic [31:0] len_field;
	} acc_t;

	localparam acc_t ACC_RESET = '{hdr_bad: 1'b0, pkg_ver: 32'd0, stored_crc: 16'd0,
		run_crc: CRC_INIT, len_field: 32'd0};

	// One entry of the reflected CRC-16 table (polynomial 0xA001).
	function automatic logic [15:0] crc_tab(input logic [7:0] idx);
		logic [15:0] c;
		c = {8'h00, idx};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Table-driven byte step of the CRC register.
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		return (crc >> 8) ^ crc_tab(crc[7:0] ^ b);
	endfunction

	// Nibbles weighted 1000, 100, 10 and 1; nibbles above nine are taken as they are.
	function automatic logic [14:0] bcd_weight(input logic [15:0] v);
		return 15'(v[15:12]) * 15'd1000 + 15'(v[11:8]) * 15'd100 +
			15'(v[7:4]) * 15'd10 + 15'(v[3:0]);
	endfunction

endpackage

// ===== sv/fpv_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the firmware package validator:
// package bytes in, results out, and the configuration write channel.
// Depends on fpv_pkg for the field widths.
interface fpv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fpv_res_if import fpv_pkg::*;;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [15:0]       computed_crc;
	logic [DLEN_W-1:0] data_length;
	modport source (output valid, output status, output computed_crc,
		output data_length, input ready);
	modport sink (input valid, input status, input computed_crc,
		input data_length, output ready);
endinterface

interface fpv_cfg_if import fpv_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic                  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/fpv_state.sv =====
`timescale 1ns / 1ps
// Running state of one package: byte count, magic check, version, stored
// CRC, length field and the CRC register, with their values after this byte.
// Depends on fpv_pkg.
module fpv_state import fpv_pkg::*; #(
	parameter int unsigned MAX_FILE_BYTES = MAX_FILE_BYTES_DEF,
	parameter int unsigned CNT_W = $clog2(MAX_FILE_BYTES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output logic [CNT_W-1:0] cnt_upd,
	output acc_t             acc_upd
);

	logic [CNT_W-1:0] cnt_q;
	acc_t             acc_q;

	// Bytes beyond the size limit leave everything as it is.
	always_comb begin
		acc_upd = acc_q;
		cnt_upd = cnt_q;
		if (cnt_q < CNT_W'(MAX_FILE_BYTES)) begin
			if (cnt_q < CNT_W'(POS_VER)) begin
				if (data_byte != MAGIC[cnt_q[2:0]]) begin
					acc_upd.hdr_bad = 1'b1;
				end
			end else if (cnt_q < CNT_W'(POS_CRC_FIELD)) begin
				acc_upd.pkg_ver = {acc_q.pkg_ver[23:0], data_byte};
			end else if (cnt_q < CNT_W'(POS_CRC_START)) begin
				acc_upd.stored_crc = {acc_q.stored_crc[7:0], data_byte};
			end
			if (cnt_q >= CNT_W'(POS_CRC_START)) begin
				if (cnt_q < CNT_W'(POS_LEN_END)) begin
					acc_upd.len_field = {acc_q.len_field[23:0], data_byte};
				end
				acc_upd.run_crc = crc_step(acc_q.run_crc, data_byte);
			end
			cnt_upd = cnt_q + CNT_W'(1);
		end
	end

	// The final byte clears the state for the next package.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			acc_q <= ACC_RESET;
		end else if (step) begin
			if (last_byte) begin
				cnt_q <= '0;
				acc_q <= ACC_RESET;
			end else begin
				cnt_q <= cnt_upd;
				acc_q <= acc_upd;
			end
		end
	end

endmodule

// ===== sv/fpv_verdict.sv =====
`timescale 1ns / 1ps
// Result of a finished package: status by check priority, byte-swapped CRC
// and data length, formed from the state after its final byte.
// Depends on fpv_pkg.
module fpv_verdict import fpv_pkg::*; #(
	parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int unsigned CNT_W = $clog2(MAX_FILE_BYTES_DEF + 1)
) (
	input  logic [CNT_W-1:0]  cnt,
	input  acc_t              acc,
	input  logic [31:0]       cur_ver,
	input  logic              ver_en,
	output logic [2:0]        status,
	output logic [15:0]       crc_out,
	output logic [DLEN_W-1:0] dlen
);

	logic trunc;

	assign crc_out = {acc.run_crc[7:0], acc.run_crc[15:8]};
	assign trunc   = cnt < CNT_W'(HEADER_BYTES);
	assign dlen    = trunc ? '0 : DLEN_W'(cnt - CNT_W'(HEADER_BYTES));

	always_comb begin
		priority if (trunc) begin
			status = ST_TRUNC;
		end else if (acc.hdr_bad) begin
			status = ST_HEADER;
		end else if (ver_en && (cur_ver[31:16] != acc.pkg_ver[31:16])) begin
			status = ST_MAJOR;
		end else if (ver_en &&
				(bcd_weight(cur_ver[15:0]) >= bcd_weight(acc.pkg_ver[15:0]))) begin
			status = ST_MINOR;
		end else if (acc.stored_crc != crc_out) begin
			status = ST_CRC;
		end else if (acc.len_field != 32'(dlen)) begin
			status = ST_LENGTH;
		end else begin
			status = ST_OK;
		end
	end

endmodule

// ===== sv/firmware_package_validator_top.sv =====
`timescale 1ns / 1ps
// Firmware package validator. It takes one package byte per cycle while no
// final byte is stalled, the final byte marked by last_byte, and presents one
// result word per package once that final byte has been accepted: the byte sits
// in the input register while the table CRC step and the check logic work on
// it, and the result register is loaded as it moves on. The CRC table step for
// a byte and the status logic are combinational between the input register and
// the result register, which is what holds the rate at one byte per cycle. A
// finished result may wait in its register while the next package streams in;
// only a second final byte stalls until the first result is taken. Bytes past
// MAX_FILE_BYTES are neither counted nor checksummed. Configuration words
// (index 0 installed version, index 1 version check enable) are taken at any
// time and should be written only while no package is in flight.
// Depends on fpv_pkg, fpv_if, fpv_state and fpv_verdict.
module firmware_package_validator_top import fpv_pkg::*; #(
	parameter int unsigned MAX_FILE_BYTES = MAX_FILE_BYTES_DEF,
	parameter int unsigned HEADER_BYTES   = HEADER_BYTES_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	fpv_byte_if.sink   pkt,
	fpv_res_if.source  res,
	fpv_cfg_if.sink    cfg
);

	localparam int unsigned CNT_W = $clog2(MAX_FILE_BYTES + 1);

	// Configuration registers.
	logic [31:0] cur_ver_q;
	logic        ver_en_q;

	// Input register.
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Result register.
	logic              res_v_q;
	logic [2:0]        status_q;
	logic [15:0]       crc_q;
	logic [DLEN_W-1:0] dlen_q;

	logic              out_free;
	logic              adv;
	logic [CNT_W-1:0]  cnt_upd;
	acc_t              acc_upd;
	logic [2:0]        status_nx;
	logic [15:0]       crc_nx;
	logic [DLEN_W-1:0] dlen_nx;

	// The word in the input register moves on unless it is a final byte and
	// the result register is still occupied.
	assign out_free  = !res_v_q || res.ready;
	assign adv       = v_s1 && (!last_s1 || out_free);
	assign pkt.ready = !v_s1 || adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ver_q <= '0;
			ver_en_q  <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_CUR_VER: cur_ver_q <= cfg.data;
				CFG_VER_EN:  ver_en_q  <= cfg.data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pkt.ready) begin
			v_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			byte_s1 <= pkt.data_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	fpv_state #(
		.MAX_FILE_BYTES(MAX_FILE_BYTES),
		.CNT_W(CNT_W)
	) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.data_byte(byte_s1),
		.last_byte(last_s1),
		.cnt_upd(cnt_upd),
		.acc_upd(acc_upd)
	);

	fpv_verdict #(
		.HEADER_BYTES(HEADER_BYTES),
		.CNT_W(CNT_W)
	) u_verdict (
		.cnt(cnt_upd),
		.acc(acc_upd),
		.cur_ver(cur_ver_q),
		.ver_en(ver_en_q),
		.status(status_nx),
		.crc_out(crc_nx),
		.dlen(dlen_nx)
	);

	// A result is loaded when a final byte moves on, and held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			status_q <= status_nx;
			crc_q    <= crc_nx;
			dlen_q   <= dlen_nx;
		end
	end

	assign res.valid        = res_v_q;
	assign res.status       = status_q;
	assign res.computed_crc = crc_q;
	assign res.data_length  = dlen_q;

`ifndef SYNTH
	// A final byte that moves on always leaves a result behind it.
	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> res_v_q)
		else $error("final byte did not produce a result");

	// A truncated package reports no data length.
	a_trunc_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && (status_q == ST_TRUNC) |-> dlen_q == '0)
		else $error("truncated result with non-zero length");

	// A waiting result is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && !res.ready |=> $stable(status_q) && $stable(crc_q) && $stable(dlen_q))
		else $error("pending result overwritten");
`endif

endmodule
